>>> hw/rtl/hrw_pkg.sv
// Shared constants, types and codes of the hybrid region weight block.
// No dependencies; every other file of the block imports this package.
package hrw_pkg;

    // Field widths
    localparam int OFFSET_W = 24;
    localparam int REG_W    = 23;
    localparam int WEIGHT_W = 17;
    localparam int SLOPE_W  = 24;
    localparam int IDX_W    = 2;

    // Register indexes of the configuration port
    localparam logic [IDX_W-1:0] CFG_EXPLICIT = 2'd0;
    localparam logic [IDX_W-1:0] CFG_HYBRID   = 2'd1;

    // Default distance fraction bits
    localparam int DIST_FRAC_BITS_DEF = 14;

    // Q40 reciprocal of the hybrid width, split for two narrow multipliers
    localparam int RECIP_FRAC = 40;
    localparam int SCALE_W    = RECIP_FRAC + 1;
    localparam int RL_W       = 21;
    localparam int RH_W       = SCALE_W - RL_W;
    localparam int CNT_W      = 6;

    // Datapath widths
    localparam int AMAG_W = 24;
    localparam int T_W    = AMAG_W + SCALE_W - 16;   // t = amag * r >> 16
    localparam int TLO_W  = 30;                      // t at or above 2^30 saturates
    localparam int TM1_W  = TLO_W + 1;
    localparam int PP_W   = TLO_W + TM1_W;
    localparam int P_W    = 34;                      // p held at 2^33
    localparam int G_W    = 43;                      // g held at 2^42
    localparam int Q24_W  = 25;
    localparam int INNER_W = 29;
    localparam int GSUM_W = G_W + SCALE_W;
    localparam int PROD_W = GSUM_W + 5;

    localparam logic [Q24_W-1:0] ONE_Q24 = 25'h100_0000;
    localparam logic [P_W-1:0]   P_CAP   = 34'h2_0000_0000;
    localparam logic [G_W-1:0]   G_CAP   = 43'h400_0000_0000;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'h1_0000;

    // Status of the reciprocal unit
    typedef struct packed {
        logic busy;
        logic done;
    } hrw_recip_stat_t;

endpackage

>>> hw/rtl/hrw_if.sv
// Handshake channels of the hybrid region weight block: input, result, config.
// Depends on hrw_pkg for the field widths.
interface hrw_in_if import hrw_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [OFFSET_W-1:0] offset;
    modport source (output valid, offset, input ready);
    modport sink   (input valid, offset, output ready);
endinterface

interface hrw_out_if import hrw_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic [WEIGHT_W-1:0]       weight;
    logic signed [SLOPE_W-1:0] weight_slope;
    modport source (output valid, weight, weight_slope, input ready);
    modport sink   (input valid, weight, weight_slope, output ready);
endinterface

interface hrw_cfg_if import hrw_pkg::*;;
    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [REG_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/hrw_recip.sv
// Restoring divider forming floor(2^40 / divisor), one quotient bit a cycle.
// Depends on hrw_pkg.
module hrw_recip
    import hrw_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [REG_W-1:0]     divisor,
    output logic [SCALE_W-1:0]   quot,
    output hrw_recip_stat_t      stat
);

    logic [REG_W-1:0]   div_reg;
    logic [REG_W-1:0]   rem_reg, rem_next;
    logic [SCALE_W-1:0] quot_reg, quot_next;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg, done_reg;
    logic [REG_W:0]     shifted;
    logic               fits;

    // Shift in the next dividend bit; only the top bit of 2^40 is set
    always_comb
    begin
        shifted   = {rem_reg, (cnt_reg == CNT_W'(RECIP_FRAC))};
        fits      = shifted >= {1'b0, div_reg};
        rem_next  = fits ? REG_W'(shifted - {1'b0, div_reg}) : REG_W'(shifted);
        quot_next = {quot_reg[SCALE_W-2:0], fits};
    end

    // Iterate from bit 40 down to bit 0
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(RECIP_FRAC);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Hold the working operands
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg  <= (divisor == '0) ? REG_W'(1) : divisor;
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign quot      = quot_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

>>> hw/rtl/hybrid_region_weight.sv
// Top level: quintic switching weight and its slope over an eight-stage pipeline.
// Depends on hrw_pkg, the channel interfaces in hrw_if and hrw_recip.
//
//   channel | dir | beat contents
//   din     | in  | offset (signed Q.14 distance from the region center)
//   dout    | out | weight (Q.16, 65536 is one), weight_slope (signed Q.16)
//   cfg     | in  | index (0 explicit_width, 1 hybrid_width), data
//
// One offset enters per cycle, unless back-pressure or the reciprocal holds din.
// The pipeline is set by the two 24x41 and 43x41 products, cut into halves.
// Stages advance on their own, so bubbles close up behind a stalled output.
// A hybrid_width write starts a 41-step reciprocal; din and cfg wait for it.
// After reset both widths are one and the reciprocal is preset, no wait.
module hybrid_region_weight
    import hrw_pkg::*;
#(
    parameter int DIST_FRAC_BITS = DIST_FRAC_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    hrw_in_if.sink     din,
    hrw_out_if.source  dout,
    hrw_cfg_if.sink    cfg
);

    localparam int NSTG     = 8;
    localparam int SLOPE_SH = 48 - DIST_FRAC_BITS;

    // Configuration
    logic [REG_W-1:0]   explicit_reg;
    logic [REG_W-1:0]   hybrid_reg;
    logic [SCALE_W-1:0] scale_reg;
    logic [SCALE_W-1:0] recip_quot;
    hrw_recip_stat_t    recip_stat;
    logic               cfg_fire, recip_start, hold;

    assign hold        = recip_stat.busy || recip_stat.done;
    assign cfg.ready   = !hold;
    assign cfg_fire    = cfg.valid && cfg.ready;
    assign recip_start = cfg_fire && (cfg.index == CFG_HYBRID);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            explicit_reg <= REG_W'(1) << DIST_FRAC_BITS;
            hybrid_reg   <= REG_W'(1) << DIST_FRAC_BITS;
            scale_reg    <= SCALE_W'(1) << (RECIP_FRAC - DIST_FRAC_BITS);
        end
        else
        begin
            if (cfg_fire && cfg.index == CFG_EXPLICIT)
                explicit_reg <= cfg.data;
            if (recip_start)
                hybrid_reg <= cfg.data;
            if (recip_stat.done)
                scale_reg <= recip_quot;
        end
    end

    hrw_recip u_recip (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (recip_start),
        .divisor (cfg.data),
        .quot    (recip_quot),
        .stat    (recip_stat)
    );

    logic [RL_W-1:0] r_lo;
    logic [RH_W-1:0] r_hi;
    assign r_lo = scale_reg[RL_W-1:0];
    assign r_hi = scale_reg[SCALE_W-1:RL_W];

    // Stage handshake: a stage loads when it is empty or its successor loads
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] en;
    logic [NSTG-1:0] below_reg, above_reg;

    always_comb
    begin
        en[NSTG-1] = !vld_reg[NSTG-1] || dout.ready;
        for (int i = NSTG - 2; i >= 0; i--)
            en[i] = !vld_reg[i] || en[i+1];
    end

    assign din.ready = en[0] && !hold;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (en[0])
                vld_reg[0] <= din.valid && din.ready;
            for (int i = 1; i < NSTG; i++)
                if (en[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    // Stage 0: distance, band flags and |d - ex|
    logic [OFFSET_W-1:0] dist_mag;
    logic [REG_W-1:0]    h_eff;
    logic                below_c, above_c;
    logic [AMAG_W-1:0]   amag_c, s0_amag_reg;

    always_comb
    begin
        dist_mag = din.offset[OFFSET_W-1] ? OFFSET_W'(-din.offset) : OFFSET_W'(din.offset);
        h_eff    = (hybrid_reg == '0) ? REG_W'(1) : hybrid_reg;
        below_c  = dist_mag < {1'b0, explicit_reg};
        above_c  = {1'b0, dist_mag} > ({2'b0, explicit_reg} + {2'b0, h_eff});
        amag_c   = below_c ? AMAG_W'({1'b0, explicit_reg} - dist_mag)
                           : AMAG_W'(dist_mag - {1'b0, explicit_reg});
    end

    // Carry band flags along the stages
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            below_reg[0] <= below_c;
            above_reg[0] <= above_c;
            s0_amag_reg  <= amag_c;
        end
        for (int i = 1; i < NSTG; i++)
            if (en[i])
            begin
                below_reg[i] <= below_reg[i-1];
                above_reg[i] <= above_reg[i-1];
            end
    end

    // Stage 1: amag times the two reciprocal halves
    logic [AMAG_W+RL_W-1:0] s1_al_reg;
    logic [AMAG_W+RH_W-1:0] s1_ah_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_al_reg <= s0_amag_reg * r_lo;
            s1_ah_reg <= s0_amag_reg * r_hi;
        end
    end

    // Stage 2: join halves into t (Q24)
    logic [AMAG_W+SCALE_W-1:0] tsum;
    logic [T_W-1:0]            s2_t_reg;

    assign tsum = {s1_ah_reg, {RL_W{1'b0}}} + (AMAG_W + SCALE_W)'(s1_al_reg);

    always_ff @(posedge clk)
    begin
        if (en[2])
            s2_t_reg <= tsum[AMAG_W+SCALE_W-1:16];
    end

    // Stage 3: clamp t, form |t - 1| (t + 1 if below), square t and multiply t by it
    logic [Q24_W-1:0]   tc;
    logic [TLO_W-1:0]   tlo;
    logic               tsat;
    logic [TM1_W-1:0]   tm1;
    logic [2*Q24_W-1:0] tsq;
    logic [Q24_W-1:0]   s3_tc_reg, s3_t2_reg;
    logic [PP_W-1:0]    s3_pp_reg;
    logic               s3_tsat_reg;

    always_comb
    begin
        tsat = |s2_t_reg[T_W-1:TLO_W];
        tlo  = s2_t_reg[TLO_W-1:0];
        tc   = (s2_t_reg > T_W'(ONE_Q24)) ? ONE_Q24 : s2_t_reg[Q24_W-1:0];
        if (below_reg[2])
            tm1 = {1'b0, tlo} + TM1_W'(ONE_Q24);
        else if ({1'b0, tlo} >= TM1_W'(ONE_Q24))
            tm1 = {1'b0, tlo} - TM1_W'(ONE_Q24);
        else
            tm1 = TM1_W'(ONE_Q24) - {1'b0, tlo};
        tsq = tc * tc;
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_tc_reg   <= tc;
            s3_t2_reg   <= tsq[24 +: Q24_W];
            s3_pp_reg   <= tlo * tm1;
            s3_tsat_reg <= tsat;
        end
    end

    // Stage 4: t^3, inner polynomial, p held and squared into g
    logic [2*Q24_W-1:0] t3_full;
    logic [INNER_W-1:0] inner;
    logic [PP_W-25:0]   p_full;
    logic [P_W-1:0]     p_c;
    logic [2*P_W-1:0]   psq;
    logic [2*P_W-25:0]  g_full;
    logic [Q24_W-1:0]   s4_t3_reg;
    logic [INNER_W-1:0] s4_inner_reg;
    logic [G_W-1:0]     s4_g_reg;

    always_comb
    begin
        t3_full = s3_t2_reg * s3_tc_reg;
        inner   = INNER_W'(10) * INNER_W'(ONE_Q24) + INNER_W'(6) * INNER_W'(s3_t2_reg)
                  - INNER_W'(15) * INNER_W'(s3_tc_reg);
        p_full  = s3_pp_reg[PP_W-1:24];
        p_c     = (s3_tsat_reg || |p_full[PP_W-25:P_W-1]) ? P_CAP : P_W'(p_full);
        psq     = p_c * p_c;
        g_full  = psq[2*P_W-1:24];
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_t3_reg    <= t3_full[24 +: Q24_W];
            s4_inner_reg <= inner;
            s4_g_reg     <= (g_full > (2*P_W-24)'(G_CAP)) ? G_CAP : G_W'(g_full);
        end
    end

    // Stage 5: S = t^3 * inner, g times the reciprocal halves
    logic [Q24_W+INNER_W-1:0] s_full;
    logic [INNER_W-1:0]       s5_s_reg;
    logic [G_W+RL_W-1:0]      s5_gl_reg;
    logic [G_W+RH_W-1:0]      s5_gh_reg;

    assign s_full = s4_t3_reg * s4_inner_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_s_reg  <= s_full[24 +: INNER_W];
            s5_gl_reg <= s4_g_reg * r_lo;
            s5_gh_reg <= s4_g_reg * r_hi;
        end
    end

    // Stage 6: round the weight or set it from the band flags, join the slope halves
    logic [Q24_W-1:0]    w24;
    logic [Q24_W-1:0]    w_round;
    logic [WEIGHT_W-1:0] w_band;
    logic [WEIGHT_W-1:0] s6_w_reg;
    logic [GSUM_W-1:0]   s6_gsum_reg;

    always_comb
    begin
        w24     = (s5_s_reg >= INNER_W'(ONE_Q24)) ? '0 : ONE_Q24 - Q24_W'(s5_s_reg);
        w_round = w24 + Q24_W'(128);
        w_band  = w_round[8 +: WEIGHT_W];
    end

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            if (below_reg[5])
                s6_w_reg <= WEIGHT_ONE;
            else if (above_reg[5])
                s6_w_reg <= '0;
            else
                s6_w_reg <= w_band;
            s6_gsum_reg <= {s5_gh_reg, {RL_W{1'b0}}} + GSUM_W'(s5_gl_reg);
        end
    end

    // Stage 7: times 30, scale down, hold at the limit and negate
    logic [PROD_W-1:0]  prod30;
    logic [PROD_W-1:0]  vshift;
    logic [SLOPE_W-1:0] vmag;
    logic [WEIGHT_W-1:0] s7_w_reg;
    logic [SLOPE_W-1:0]  s7_slope_reg;

    always_comb
    begin
        prod30 = ({s6_gsum_reg, 5'b0}) - PROD_W'({s6_gsum_reg, 1'b0});
        vshift = prod30 >> SLOPE_SH;
        vmag   = (vshift >= PROD_W'(1 << 23)) ? SLOPE_W'(1 << 23) : SLOPE_W'(vshift);
    end

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_w_reg     <= s6_w_reg;
            s7_slope_reg <= SLOPE_W'(-vmag);
        end
    end

    // Drive the result channel
    assign dout.valid        = vld_reg[NSTG-1];
    assign dout.weight       = s7_w_reg;
    assign dout.weight_slope = s7_slope_reg;

endmodule

>>> hw/rtl/hrw_checker.sv
// Port-level checks of hybrid_region_weight and the bind that attaches them.
// Depends on hrw_pkg and the top level's channel interfaces.
module hrw_checker
    import hrw_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                din_ready,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic [IDX_W-1:0]    cfg_index,
    input logic                dout_valid,
    input logic                dout_ready,
    input logic [WEIGHT_W-1:0] dout_weight,
    input logic [SLOPE_W-1:0]  dout_weight_slope
);

    // A stalled result beat holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid && !dout_ready |=> dout_valid && $stable(dout_weight)
            && $stable(dout_weight_slope))
        else $error("result beat changed while stalled");

    // A hybrid width write closes the input while the reciprocal runs
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && cfg_index == CFG_HYBRID |=> !din_ready && !cfg_ready)
        else $error("input open during reciprocal update");

    // Weight never exceeds one
    assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid |-> dout_weight <= WEIGHT_ONE)
        else $error("weight above one");

    // Slope is never positive
    assert property (@(posedge clk) disable iff (!rst_n)
        dout_valid |-> dout_weight_slope[SLOPE_W-1] || dout_weight_slope == '0)
        else $error("positive slope");

endmodule

bind hybrid_region_weight hrw_checker u_hrw_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .din_ready         (din.ready),
    .cfg_valid         (cfg.valid),
    .cfg_ready         (cfg.ready),
    .cfg_index         (cfg.index),
    .dout_valid        (dout.valid),
    .dout_ready        (dout.ready),
    .dout_weight       (dout.weight),
    .dout_weight_slope (dout.weight_slope)
);

>>> bench/hrw_test_if.sv
// Testbench-side note: channel interfaces come from the RTL file hrw_if.sv.
// Depends on hrw_pkg; holds a small shared type for the bench.
package hrw_test_pkg;
    import hrw_pkg::*;

    // One expected output beat
    typedef struct packed {
        logic [WEIGHT_W-1:0]       weight;
        logic signed [SLOPE_W-1:0] slope;
    } weight_beat_t;
endpackage

>>> bench/hybrid_region_weight_test.sv
// Self-checking bench of hybrid_region_weight: directed table, then random offsets.
// Depends on hrw_pkg, hrw_if interfaces, hrw_test_pkg and the block RTL.
module hybrid_region_weight_test;
    import hrw_pkg::*;
    import hrw_test_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = DIST_FRAC_BITS_DEF;
    localparam logic [63:0] ONE24 = 64'd1 << 24;
    localparam logic [63:0] SAT_CAP = 64'd1 << 63;
    localparam int TAIL_CYCLES = 60;
    localparam logic [IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    hrw_in_if  din();
    hrw_out_if dout();
    hrw_cfg_if cfg();

    hybrid_region_weight u_top (.clk(clk), .rst_n(rst_n), .din(din), .dout(dout), .cfg(cfg));

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Predictor state
    logic [63:0] ex_width, hy_width, recip;
    weight_beat_t expected_beats[$];
    int errors = 0;
    int beats_seen = 0;
    int send_idle = 0;
    int recv_stall = 0;

    // Directed table row
    typedef struct {
        logic signed [OFFSET_W-1:0] offset;
        bit                         known;
        logic [WEIGHT_W-1:0]        weight;
        logic signed [SLOPE_W-1:0]  slope;
    } offset_row_t;

    function automatic logic [63:0] sat_mul(logic [63:0] x, logic [63:0] y);
        if (x == 0)
            return 0;
        if (y > SAT_CAP / x)
            return SAT_CAP;
        return x * y;
    endfunction

    // Recompute the Q40 reciprocal after a hybrid_width change
    function automatic void set_widths(logic [63:0] ex, logic [63:0] hy);
        ex_width = ex;
        hy_width = hy;
        recip = (64'd1 << 40) / ((hy == 0) ? 64'd1 : hy);
    endfunction

    // Quintic weight and its slope for one offset
    function automatic weight_beat_t switching_weight(logic signed [OFFSET_W-1:0] off);
        logic [63:0] raw, d, h, amag, t, tc, t2, t3, inner, s, w24, w, tm1, p, g, v;
        bit below;
        weight_beat_t res;
        raw = {40'd0, off};
        d = raw[23] ? (64'h100_0000 - raw) : raw;
        h = (hy_width == 0) ? 64'd1 : hy_width;
        below = d < ex_width;
        amag = below ? ex_width - d : d - ex_width;
        t = (amag * recip) >> 16;
        if (below)
            w = 65536;
        else if (d > ex_width + h)
            w = 0;
        else
        begin
            tc = (t > ONE24) ? ONE24 : t;
            t2 = (tc * tc) >> 24;
            t3 = (t2 * tc) >> 24;
            inner = 10 * ONE24 + 6 * t2 - 15 * tc;
            s = (t3 * inner) >> 24;
            w24 = (s >= ONE24) ? 0 : ONE24 - s;
            w = (w24 + 128) >> 8;
            if (w > 65536)
                w = 65536;
        end
        if (below)
            tm1 = t + ONE24;
        else
            tm1 = (t >= ONE24) ? t - ONE24 : ONE24 - t;
        p = sat_mul(t, tm1) >> 24;
        g = sat_mul(p, p) >> 24;
        v = sat_mul(g, 30 * recip) >> (48 - FRAC);
        if (v > (64'd1 << 23))
            v = 64'd1 << 23;
        res.weight = w[WEIGHT_W-1:0];
        res.slope = SLOPE_W'(64'd0 - v);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // Check every output beat against the oldest expectation
    always @(posedge clk)
    begin
        weight_beat_t want;
        if (rst_n && dout.valid && dout.ready)
        begin
            beats_seen++;
            if (expected_beats.size() == 0)
                report_mismatch("unexpected beat", dout.weight, 0);
            else
            begin
                want = expected_beats.pop_front();
                if (dout.weight !== want.weight)
                    report_mismatch("weight", dout.weight, want.weight);
                if (dout.weight_slope !== want.slope)
                    report_mismatch("weight_slope", dout.weight_slope, want.slope);
            end
        end
    end

    // Receiver stall
    always @(posedge clk)
    begin
        if (!rst_n)
            dout.ready <= 1'b0;
        else
            dout.ready <= ($urandom_range(99) >= recv_stall);
    end

    // Send one offset beat; drop valid while idle, hold until accepted
    task automatic send_offset(logic signed [OFFSET_W-1:0] off, bit known,
                               weight_beat_t typed);
        while ($urandom_range(99) < send_idle)
        begin
            din.valid <= 1'b0;
            @(posedge clk);
        end
        din.valid <= 1'b1;
        din.offset <= off;
        expected_beats.push_back(known ? typed : switching_weight(off));
        @(posedge clk);
        while (!din.ready)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        cfg.valid <= 1'b0;
        if (idx == CFG_EXPLICIT)
            set_widths({41'd0, value}, hy_width);
        else if (idx == CFG_HYBRID)
            set_widths(ex_width, {41'd0, value});
        @(posedge clk);
    endtask

    task automatic drain;
        din.valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [OFFSET_W-1:0] random_offset(int mode);
        logic [63:0] span, base, d;
        span = ex_width + hy_width;
        case (mode)
            0: d = {40'd0, 24'($urandom())} & 64'hFF_FFFF;
            default:
            begin
                base = (span > 64'h7F_FFFF) ? 64'h7F_FFFF : span;
                d = $urandom_range(base + 16 > 64'h80_0000 ? 32'h80_0000 : 32'(base + 16));
                return OFFSET_W'($urandom_range(1) ? -$signed({1'b0, d[23:0]})
                                                   : {1'b0, d[23:0]});
            end
        endcase
        return d[23:0];
    endfunction

    initial
    begin
        #200000;
        $display("timeout at %0t", $realtime);
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        offset_row_t table_rows[$];
        weight_beat_t typed;
        int phase;
        din.valid = 1'b0;
        din.offset = '0;
        cfg.valid = 1'b0;
        cfg.index = CFG_EXPLICIT;
        cfg.data = '0;
        set_widths(64'd1 << FRAC, 64'd1 << FRAC);
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; known answers at center and far away
        table_rows.push_back('{24'sd0, 1, WEIGHT_ONE, -24'sd7864320});
        table_rows.push_back('{24'sh7F_FFFF, 1, 17'd0, 24'sh80_0000});
        table_rows.push_back('{24'sh80_0000, 1, 17'd0, 24'sh80_0000});
        table_rows.push_back('{24'sd16384, 0, 0, 0});
        table_rows.push_back('{-24'sd16384, 0, 0, 0});
        table_rows.push_back('{24'sd32768, 0, 0, 0});
        table_rows.push_back('{24'sd32769, 0, 0, 0});
        table_rows.push_back('{24'sd24576, 0, 0, 0});
        table_rows.push_back('{-24'sd1, 0, 0, 0});
        table_rows.push_back('{24'sd16383, 0, 0, 0});
        foreach (table_rows[i])
        begin
            typed.weight = table_rows[i].weight;
            typed.slope = table_rows[i].slope;
            send_offset(table_rows[i].offset, table_rows[i].known, typed);
        end
        drain();

        // Extreme and odd register settings, incl. zero hybrid width and bad index
        write_reg(CFG_HYBRID, '0);
        write_reg(CFG_EXPLICIT, 23'd100);
        write_reg(CFG_UNUSED, 23'h7F_FFFF);
        send_offset(24'sd100, 0, typed);
        send_offset(24'sd101, 0, typed);
        send_offset(-24'sd102, 0, typed);
        drain();
        write_reg(CFG_EXPLICIT, 23'h7F_FFFF);
        write_reg(CFG_HYBRID, 23'h7F_FFFF);
        send_offset(24'sh80_0000, 0, typed);
        send_offset(24'sh7F_FFFF, 0, typed);
        send_offset(24'sd0, 0, typed);
        drain();
        write_reg(CFG_EXPLICIT, '0);
        write_reg(CFG_HYBRID, 23'd1);
        send_offset(24'sd0, 0, typed);
        send_offset(24'sd1, 0, typed);
        send_offset(24'sd2, 0, typed);
        drain();

        // Random phases with varied settings and idling
        for (phase = 0; phase < 8; phase++)
        begin
            case (phase % 4)
                0: begin send_idle = 0;  recv_stall = 0;  end
                1: begin send_idle = 85; recv_stall = 0;  end
                2: begin send_idle = 0;  recv_stall = 85; end
                default: begin send_idle = 37; recv_stall = 37; end
            endcase
            write_reg(CFG_EXPLICIT, (phase == 7) ? '0 : 23'($urandom_range(1 << 20)));
            write_reg(CFG_HYBRID, (phase == 6) ? 23'h7F_FFFF : 23'($urandom_range(1, 1 << 19)));
            repeat (250)
                send_offset(random_offset($urandom_range(3) == 0 ? 0 : 1), 0, typed);
            drain();
        end
        $display("covered directed edges, register extremes and %0d result beats", beats_seen);
        $display("across eight random phases with sender and receiver idling");
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

>>> files.f
hw/rtl/hrw_pkg.sv
hw/rtl/hrw_if.sv
hw/rtl/hrw_recip.sv
hw/rtl/hybrid_region_weight.sv
hw/rtl/hrw_checker.sv
bench/hrw_test_if.sv
bench/hybrid_region_weight_test.sv
